/* design/bsia_pkg.sv */
// Shared command and status codes for the bounded stack unit.
package bsia_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 4;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHANGE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

endpackage

/* design/bounded_stack_with_indexed_access_unit.sv */
// Bounded LIFO stack of signed words with access by depth, top level.
// Push, change and every error result: one item per cycle unless the output stalls; result is
// registered in the cycle after acceptance. Pop and peek: store read into the read register,
// then the output register; next item taken once the word leaves the read register. Display:
// one word per cycle top to bottom unless the output stalls, paced by the store's single read
// port and the output register. Reset clears the entry count and control state; the store holds no reset value.
module bounded_stack_with_indexed_access_unit #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bsia_pkg::CMD_W-1:0]      in_command,
  input  logic signed [bsia_pkg::WORD_W-1:0] in_value,
  input  logic [bsia_pkg::POS_W-1:0]      in_position,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [bsia_pkg::WORD_W-1:0] out_data,
  output logic [bsia_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_last
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > bsia_pkg::POS_W) ? CW : bsia_pkg::POS_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DISP = 1'b1;

  logic [bsia_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bsia_pkg::WORD_W-1:0] rd_q;

  logic                           state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [AW-1:0]                  ptr_r, ptr_nxt;
  logic                           pend_r, pend_nxt;
  logic                           pend_last_r, pend_last_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [bsia_pkg::WORD_W-1:0]    out_data_r, out_data_nxt;
  logic [bsia_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           we, re;
  logic [AW-1:0]                  wa, ra;
  logic [bsia_pkg::WORD_W-1:0]    wd;

  logic                           slot_free, load, in_fire;
  logic [CW-1:0]                  cnt_m1;
  logic [CMPW-1:0]                cnt_x, pos_x, idx_x;
  logic                           bad_pos, full, empty;

  assign slot_free = !out_valid_r || out_ready;
  assign load      = pend_r && slot_free;
  assign in_ready  = (state_r == ST_IDLE) && slot_free && !pend_r;
  assign in_fire   = in_valid && in_ready;

  assign cnt_m1  = count_r - CW'(1);
  assign cnt_x   = CMPW'(count_r);
  assign pos_x   = CMPW'(in_position);
  assign idx_x   = cnt_x - pos_x - CMPW'(1);
  assign bad_pos = (pos_x >= cnt_x);
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = pend_r;
    pend_last_nxt  = pend_last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    we = 1'b0;
    re = 1'b0;
    wa = '0;
    ra = '0;
    wd = in_value;

    // hand the word in the read register to the output register
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = rd_q;
      out_status_nxt = bsia_pkg::ST_OK;
      out_last_nxt   = pend_last_r;
      pend_nxt       = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_command)
            bsia_pkg::CMD_PUSH: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_status_nxt = bsia_pkg::ST_OVERFLOW;
              end else begin
                we = 1'b1;
                wa = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
                out_status_nxt = bsia_pkg::ST_OK;
              end
            end
            bsia_pkg::CMD_POP: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = bsia_pkg::ST_UNDERFLOW;
                out_last_nxt   = 1'b1;
              end else begin
                re = 1'b1;
                ra = cnt_m1[AW-1:0];
                count_nxt     = cnt_m1;
                pend_nxt      = 1'b1;
                pend_last_nxt = 1'b1;
              end
            end
            bsia_pkg::CMD_PEEK: begin
              if (bad_pos) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = bsia_pkg::ST_BADPOS;
                out_last_nxt   = 1'b1;
              end else begin
                re = 1'b1;
                ra = idx_x[AW-1:0];
                pend_nxt      = 1'b1;
                pend_last_nxt = 1'b1;
              end
            end
            bsia_pkg::CMD_CHANGE: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_last_nxt  = 1'b1;
              if (bad_pos) begin
                out_status_nxt = bsia_pkg::ST_BADPOS;
              end else begin
                we = 1'b1;
                wa = idx_x[AW-1:0];
                out_status_nxt = bsia_pkg::ST_OK;
              end
            end
            bsia_pkg::CMD_DISPLAY: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = bsia_pkg::ST_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                ptr_nxt   = cnt_m1[AW-1:0];
                state_nxt = ST_DISP;
              end
            end
            default: begin
              // unknown command: drop the item
            end
          endcase
        end
      end
      ST_DISP: begin
        // issue the next read whenever the read register is free or being drained
        if (!pend_r || load) begin
          re = 1'b1;
          ra = ptr_r;
          pend_nxt      = 1'b1;
          pend_last_nxt = (ptr_r == '0);
          if (ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt = ptr_r - AW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    pend_last_r  <= pend_last_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule
